### rtl/sfd_pkg.sv
// sfd_pkg: shared types and constants for the slip frame decoder
// slip byte codes, result kinds, frame counter width and limit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam logic [7:0] BYTE_END     = 8'o300;
    localparam logic [7:0] BYTE_ESC     = 8'o333;
    localparam logic [7:0] BYTE_ESC_END = 8'o334;
    localparam logic [7:0] BYTE_ESC_ESC = 8'o335;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 12;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
    localparam int COUNT_LIMIT_I   =
        (MAX_FRAME_BYTES < COUNT_MAX) ? MAX_FRAME_BYTES : COUNT_MAX;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_I);

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] len;
    } t_result;

endpackage

`default_nettype wire

### rtl/sfd_decode.sv
// sfd_decode: slip un-stuffing state (escape, discard, frame count)
// turns one registered byte into at most one result
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_decode (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [sfd_pkg::BYTE_W-1:0] i_byte,
    output sfd_pkg::t_result               o_result
);
    import sfd_pkg::*;

    logic               r_esc, n_esc;
    logic               r_disc, n_disc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] cnt_inc;

    assign cnt_inc = (r_cnt < COUNT_LIMIT) ? r_cnt + COUNT_W'(1) : r_cnt;

    always_comb begin
        n_esc    = r_esc;
        n_disc   = r_disc;
        n_cnt    = r_cnt;
        o_result = '{vld: 1'b0, kind: KIND_DATA, data: '0, len: '0};
        if (i_step) begin
            if (r_disc) begin
                if (i_byte == BYTE_END) begin
                    n_disc = 1'b0;
                    n_esc  = 1'b0;
                    n_cnt  = '0;
                end
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_byte == BYTE_ESC_END) begin
                    n_cnt    = cnt_inc;
                    o_result = '{vld: 1'b1, kind: KIND_DATA, data: BYTE_END, len: '0};
                end else if (i_byte == BYTE_ESC_ESC) begin
                    n_cnt    = cnt_inc;
                    o_result = '{vld: 1'b1, kind: KIND_DATA, data: BYTE_ESC, len: '0};
                end else begin
                    n_cnt    = '0;
                    n_disc   = (i_byte != BYTE_END);
                    o_result = '{vld: 1'b1, kind: KIND_ERROR, data: '0, len: '0};
                end
            end else if (i_byte == BYTE_ESC) begin
                n_esc = 1'b1;
            end else if (i_byte == BYTE_END) begin
                n_cnt    = '0;
                o_result = '{vld: 1'b1, kind: KIND_END, data: '0, len: r_cnt};
            end else begin
                n_cnt    = cnt_inc;
                o_result = '{vld: 1'b1, kind: KIND_DATA, data: i_byte, len: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_disc <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_esc  <= n_esc;
            r_disc <= n_disc;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/sfd_out_reg.sv
// sfd_out_reg: result register toward the output channel
// holds a result until the downstream transfer completes
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  sfd_pkg::t_result      i_result,
    input  wire logic             i_stall,
    output logic                  o_free,
    output sfd_pkg::t_result      o_result
);
    import sfd_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load && i_result.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_result.vld) begin
            r_res <= i_result;
        end
    end

    always_comb begin
        o_result     = r_res;
        o_result.vld = r_vld;
    end

endmodule

`default_nettype wire

### rtl/slip_frame_decoder.sv
// slip_frame_decoder: slip byte un-stuffing, one received byte per transfer
// a result reaches the outputs through the input register and then the result register
// throughput: one byte per cycle while the output is not stalled
// reset: synchronous active-low i_rst_n clears flags, frame count and both valid bits
// depends on sfd_pkg, sfd_decode, sfd_out_reg
`timescale 1ns / 1ps
`default_nettype none

module slip_frame_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [sfd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sfd_pkg::KIND_W-1:0]       o_kind,
    output logic [sfd_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [sfd_pkg::COUNT_W-1:0]      o_frame_length
);
    import sfd_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              out_free;
    logic              step;
    t_result           dec_res;
    t_result           out_res;

    assign step    = r_in_vld && out_free;
    assign o_stall = r_in_vld && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (dec_res)
    );

    sfd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (dec_res),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign o_valid        = out_res.vld;
    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data;
    assign o_frame_length = out_res.len;

endmodule

`default_nettype wire

### rtl/sfd_checker.sv
// sfd_checker: port-level assertions for slip_frame_decoder
// bound to the top level; depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [sfd_pkg::KIND_W-1:0] o_kind,
    input wire logic [sfd_pkg::BYTE_W-1:0] o_data_byte,
    input wire logic [sfd_pkg::COUNT_W-1:0] o_frame_length
);
    import sfd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_frame_length))
        else $error("stalled result changed");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_data_byte == '0)
        else $error("data byte not zero outside data result");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_END |-> o_frame_length == '0)
        else $error("frame length not zero outside frame end");

    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END |-> o_frame_length <= COUNT_LIMIT)
        else $error("frame length beyond limit");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_frame_length (o_frame_length)
);

`default_nettype wire
